/* design/transfer_slice_splitter_unit_assert.svh */
// Assertion macros shared by the splitter modules.
// Both expect clk_i and rst_ni in scope.
`ifndef TRANSFER_SLICE_SPLITTER_UNIT_ASSERT_SVH
`define TRANSFER_SLICE_SPLITTER_UNIT_ASSERT_SVH

// Clocked property, ignored while reset is asserted.
`define TSS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication from a trigger to a consequence.
`define TSS_ASSERT_IMP(lbl, trig, cons, msg) \
  `TSS_ASSERT_RST(lbl, (trig) |-> (cons), msg)

`endif

/* design/tss_pkg.sv */
`timescale 1ns / 1ps

package tss_pkg;

  localparam int BlockSizeW = 32;
  localparam int CountW     = 5;
  localparam int AddrW      = 64;
  localparam int SliceLenW  = 40;
  localparam int SliceNumW  = 6;
  localparam int WorkerW    = 4;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 32;

  localparam int MaxSlicesDef  = 64;
  localparam int MaxWorkersDef = 16;
  localparam int LengthBitsDef = 40;

  localparam int WriteCap = 32;
  localparam int ReadCap  = 64;

  localparam logic [BlockSizeW-1:0] BlockSizeRst   = 32'd65536;
  localparam logic [CountW-1:0]     WorkerCountRst = 5'd1;
  localparam logic [CountW-1:0]     DeviceCountRst = 5'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_SIZE   = 2'd0,
    CFG_WORKER_COUNT = 2'd1,
    CFG_DEVICE_COUNT = 2'd2
  } cfg_idx_e;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* design/tss_if.sv */
`timescale 1ns / 1ps

interface tss_req_if #(
  parameter int LengthBits = tss_pkg::LengthBitsDef
);
  import tss_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [LengthBits-1:0] transfer_length;
  logic [AddrW-1:0]      source_address;
  logic [AddrW-1:0]      remote_offset;

  modport source (
    output valid, command, transfer_length, source_address, remote_offset,
    input  ready
  );
  modport sink (
    input  valid, command, transfer_length, source_address, remote_offset,
    output ready
  );
endinterface

interface tss_slice_if;
  import tss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [AddrW-1:0]     slice_source;
  logic [AddrW-1:0]     slice_target;
  logic [SliceLenW-1:0] slice_length;
  logic [SliceNumW-1:0] slice_number;
  logic [WorkerW-1:0]   worker_index;
  logic                 last_slice;

  modport source (
    output valid, slice_source, slice_target, slice_length, slice_number,
           worker_index, last_slice,
    input  ready
  );
  modport sink (
    input  valid, slice_source, slice_target, slice_length, slice_number,
           worker_index, last_slice,
    output ready
  );
endinterface

interface tss_cfg_if;
  import tss_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/tss_divider.sv */
`timescale 1ns / 1ps

module tss_divider #(
  parameter int DividendW = tss_pkg::LengthBitsDef,
  parameter int DivisorW  = tss_pkg::BlockSizeW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DividendW-1:0]  dividend_i,
  input  logic [DivisorW-1:0]   divisor_i,
  output tss_pkg::div_stat_t    stat_o,
  output logic [DividendW-1:0]  quotient_o,
  output logic [DivisorW-1:0]   remainder_o
);
  import tss_pkg::*;

  `include "transfer_slice_splitter_unit_assert.svh"

  localparam int CntW = $clog2(DividendW + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  dvs_q, dvs_d;
  logic [DivisorW:0]    trial;
  logic                 fits;

  // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial  = {rem_q, quo_q[DividendW-1]};
    fits   = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DividendW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DividendW-2:0], fits};
      rem_d = fits ? DivisorW'(trial - {1'b0, dvs_q}) : trial[DivisorW-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

  `TSS_ASSERT_IMP(a_div_no_restart, start_i, !busy_q, "divider restarted while busy")
  `TSS_ASSERT_RST(a_div_done_pulse, done_q |=> !done_q, "divider done held longer than one cycle")
  `TSS_ASSERT_RST(a_div_busy_done, !(busy_q && done_q), "divider busy and done together")

endmodule

/* design/transfer_slice_splitter_unit.sv */
`timescale 1ns / 1ps

// Transfer slice splitter: takes one transfer request and emits its slices, one item per
// slice, in order. A request goes through three divisions on one shared radix-2 divider
// (length by block size for the slice count, length by count for the per-slice share,
// share by block size for the rounding), one after another; sink stalls hold back the
// emission of slices. A zero-length request starts no division and emits nothing.
// The request channel is ready only while no request is in work; the last slice may still
// wait in the output register while the next request is taken.
module transfer_slice_splitter_unit #(
  parameter int MaxSlices  = tss_pkg::MaxSlicesDef,
  parameter int MaxWorkers = tss_pkg::MaxWorkersDef,
  parameter int LengthBits = tss_pkg::LengthBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tss_cfg_if.sink     cfg_i,
  tss_req_if.sink     req_i,
  tss_slice_if.source slice_o
);
  import tss_pkg::*;

  `include "transfer_slice_splitter_unit_assert.svh"

  localparam int NW    = $clog2(MaxSlices + 1);
  localparam int SW    = ((LengthBits > BlockSizeW) ? LengthBits : BlockSizeW) + 1;
  localparam int WrCap = (WriteCap < MaxSlices) ? WriteCap : MaxSlices;
  localparam int RdCap = (ReadCap < MaxSlices) ? ReadCap : MaxSlices;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_DIV_N   = 5'b00010,
    S_DIV_PER = 5'b00100,
    S_DIV_Q   = 5'b01000,
    S_EMIT    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [BlockSizeW-1:0] bs_q;
  logic [CountW-1:0]     wc_q, dc_q;
  logic [BlockSizeW-1:0] bs_eff;
  logic [CountW-1:0]     wc_eff, dc_eff;

  logic [LengthBits-1:0] len_q, len_d;
  logic [AddrW-1:0]      src_q, src_d;
  logic [AddrW-1:0]      tgt_q, tgt_d;
  logic [NW-1:0]         cap_q, cap_d;
  logic [NW-1:0]         n_q, n_d;
  logic [LengthBits-1:0] per_q, per_d;
  logic [SW-1:0]         size_q, size_d;
  logic [LengthBits-1:0] left_q, left_d;
  logic [NW-1:0]         k_q, k_d;
  logic [CountW-1:0]     dev_q, dev_d;
  logic [CountW-1:0]     wrk_q, wrk_d;

  logic                  out_valid_q, out_valid_d;
  logic [AddrW-1:0]      out_src_q, out_src_d;
  logic [AddrW-1:0]      out_tgt_q, out_tgt_d;
  logic [SliceLenW-1:0]  out_len_q, out_len_d;
  logic [SliceNumW-1:0]  out_num_q, out_num_d;
  logic [WorkerW-1:0]    out_wrk_q, out_wrk_d;
  logic                  out_last_q, out_last_d;

  logic                  div_start;
  logic [LengthBits-1:0] div_dividend;
  logic [BlockSizeW-1:0] div_divisor;
  div_stat_t             div_stat;
  logic [LengthBits-1:0] div_quo;
  logic [BlockSizeW-1:0] div_rem;
  logic [LengthBits-1:0] div_ceil;

  logic                  req_fire;
  logic                  emit_load;
  logic                  slice_last;
  logic [LengthBits-1:0] slen;

  tss_divider #(
    .DividendW (LengthBits),
    .DivisorW  (BlockSizeW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Configuration registers, always writable.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q <= BlockSizeRst;
      wc_q <= WorkerCountRst;
      dc_q <= DeviceCountRst;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_BLOCK_SIZE:   bs_q <= cfg_i.data[BlockSizeW-1:0];
        CFG_WORKER_COUNT: wc_q <= cfg_i.data[CountW-1:0];
        CFG_DEVICE_COUNT: dc_q <= cfg_i.data[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Zero counts act as one; worker count saturates at the worker limit.
  always_comb begin
    bs_eff = (bs_q == '0) ? BlockSizeW'(1) : bs_q;
    dc_eff = (dc_q == '0) ? CountW'(1) : dc_q;
    if (wc_q == '0) begin
      wc_eff = CountW'(1);
    end else if ({2'b00, wc_q} > 7'(MaxWorkers)) begin
      wc_eff = CountW'(MaxWorkers);
    end else begin
      wc_eff = wc_q;
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign div_ceil    = div_quo + LengthBits'(div_rem != '0);
  assign emit_load   = (state_q == S_EMIT) && (!out_valid_q || slice_o.ready);
  assign slice_last  = (k_q + NW'(1)) == n_q;
  assign slen        = (SW'(left_q) < size_q) ? left_q : LengthBits'(size_q);

  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    src_d        = src_q;
    tgt_d        = tgt_q;
    cap_d        = cap_q;
    n_d          = n_q;
    per_d        = per_q;
    size_d       = size_q;
    left_d       = left_q;
    k_d          = k_q;
    dev_d        = dev_q;
    wrk_d        = wrk_q;
    div_start    = 1'b0;
    div_dividend = len_q;
    div_divisor  = bs_eff;

    out_valid_d  = out_valid_q;
    out_src_d    = out_src_q;
    out_tgt_d    = out_tgt_q;
    out_len_d    = out_len_q;
    out_num_d    = out_num_q;
    out_wrk_d    = out_wrk_q;
    out_last_d   = out_last_q;
    if (slice_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        div_dividend = req_i.transfer_length;
        if (req_fire) begin
          len_d = req_i.transfer_length;
          src_d = req_i.source_address;
          tgt_d = req_i.remote_offset;
          cap_d = req_i.command ? NW'(WrCap) : NW'(RdCap);
          // Drop zero-length requests: no slices.
          if (req_i.transfer_length != '0) begin
            div_start = 1'b1;
            state_d   = S_DIV_N;
          end
        end
      end
      S_DIV_N: begin
        if (div_stat.done) begin
          n_d          = (div_ceil > LengthBits'(cap_q)) ? cap_q : NW'(div_ceil);
          div_start    = 1'b1;
          div_dividend = len_q;
          div_divisor  = BlockSizeW'(n_d);
          state_d      = S_DIV_PER;
        end
      end
      S_DIV_PER: begin
        if (div_stat.done) begin
          per_d        = div_ceil;
          div_start    = 1'b1;
          div_dividend = div_ceil;
          state_d      = S_DIV_Q;
        end
      end
      S_DIV_Q: begin
        if (div_stat.done) begin
          // Round the share up to a block multiple.
          size_d  = SW'(per_q) +
                    ((div_rem != '0) ? (SW'(bs_eff) - SW'(div_rem)) : SW'(0));
          left_d  = len_q;
          k_d     = '0;
          dev_d   = '0;
          wrk_d   = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_load) begin
          out_valid_d = 1'b1;
          out_src_d   = src_q;
          out_tgt_d   = tgt_q;
          out_len_d   = SliceLenW'(slen);
          out_num_d   = SliceNumW'(k_q);
          out_wrk_d   = wrk_q[WorkerW-1:0];
          out_last_d  = slice_last;
          left_d      = left_q - slen;
          src_d       = src_q + AddrW'(slen);
          tgt_d       = tgt_q + AddrW'(slen);
          k_d         = k_q + NW'(1);
          // Advance the worker after every device_count slices.
          if (dev_q + CountW'(1) == dc_eff) begin
            dev_d = '0;
            wrk_d = (wrk_q + CountW'(1) == wc_eff) ? '0 : wrk_q + CountW'(1);
          end else begin
            dev_d = dev_q + CountW'(1);
          end
          if (slice_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    src_q      <= src_d;
    tgt_q      <= tgt_d;
    cap_q      <= cap_d;
    n_q        <= n_d;
    per_q      <= per_d;
    size_q     <= size_d;
    left_q     <= left_d;
    k_q        <= k_d;
    dev_q      <= dev_d;
    wrk_q      <= wrk_d;
    out_src_q  <= out_src_d;
    out_tgt_q  <= out_tgt_d;
    out_len_q  <= out_len_d;
    out_num_q  <= out_num_d;
    out_wrk_q  <= out_wrk_d;
    out_last_q <= out_last_d;
  end

  assign slice_o.valid        = out_valid_q;
  assign slice_o.slice_source = out_src_q;
  assign slice_o.slice_target = out_tgt_q;
  assign slice_o.slice_length = out_len_q;
  assign slice_o.slice_number = out_num_q;
  assign slice_o.worker_index = out_wrk_q;
  assign slice_o.last_slice   = out_last_q;

  `TSS_ASSERT_IMP(a_slice_in_range, state_q == S_EMIT, k_q < n_q,
                  "slice index ran past the slice count")
  `TSS_ASSERT_IMP(a_worker_in_range, state_q == S_EMIT, (wrk_q < wc_eff) && (dev_q < dc_eff),
                  "worker or device counter out of range")
  `TSS_ASSERT_IMP(a_last_covers, emit_load && slice_last, SW'(left_q) <= size_q,
                  "last slice leaves bytes uncovered")
  `TSS_ASSERT_IMP(a_div_idle_on_accept, req_fire, !div_stat.busy,
                  "request taken while the divider is busy")

endmodule
